// ===== hdl/rnpw_pkg.sv =====
package rnpw_pkg;

    // Byte addresses are formed in this width before they are cut to the
    // memory depth or to the 18-bit result field.
    localparam int WIDE_W = 24;
    typedef logic [WIDE_W-1:0] t_waddr;

    localparam logic [7:0] FILL_BYTE = 8'hFF;
    localparam int         CFG_ENABLE_IDX = 0;

    typedef enum logic [1:0] {
        KIND_GRAY8 = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_GRAY3 = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_WRITTEN = 3'd0,
        ST_SKIPPED = 3'd1,
        ST_CLIPPED = 3'd2,
        ST_READ    = 3'd3,
        ST_REFUSED = 3'd4
    } t_status;

    // One access to the frame memory.
    typedef struct packed {
        logic       en;
        logic       we;
        t_waddr     addr;
        logic [7:0] wdata;
    } t_mem_req;

endpackage

// ===== hdl/rnpw_frame_mem.sv =====
module rnpw_frame_mem #(
    parameter int DEPTH = 259200
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rnpw_pkg::t_mem_req  i_req,
    output logic [7:0]          o_rdata,
    output logic                o_clr_busy
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        r_rdata;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic [ADDR_W-1:0] req_idx;

    assign req_idx = i_req.addr[ADDR_W-1:0];

    // After reset every byte is swept to white, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_cnt] <= rnpw_pkg::FILL_BYTE;
        end else if (i_req.en && i_req.we) begin
            mem[req_idx] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rdata <= mem[req_idx];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== hdl/rnpw_apb_regs.sv =====
module rnpw_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_drawing_enabled
);

    logic r_drawing_enabled;
    logic hit;

    assign hit    = (paddr[2] == 1'(rnpw_pkg::CFG_ENABLE_IDX));
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing_enabled <= 1'b0;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_drawing_enabled <= pwdata[0];
        end
    end

    assign prdata            = hit ? {31'd0, r_drawing_enabled} : 32'd0;
    assign o_drawing_enabled = r_drawing_enabled;

endmodule

// ===== hdl/rotated_nibble_pixel_writer_unit.sv =====
// Packed 4-bit-per-pixel framebuffer writer. Each input word is either one
// pixel write, given in logical portrait coordinates, or one byte read; every
// input word yields exactly one result word. A pixel write is rotated to
// physical row PANEL_HEIGHT-1-x and column y, clipped, converted to a nibble
// and merged into its byte by read-modify-write (odd columns in the upper
// nibble). An item passes through acceptance, address and nibble computation
// (the row multiply), the synchronous frame memory read, and the merge with
// write-back; the single memory port means that a new word is accepted only
// once the last one has left its merge step. A finished result sits in an output
// register and does not hold up acceptance of the next input word; that word
// waits at its merge until the register is free. After reset the frame memory
// is swept to white, one byte per cycle; no input word is taken during that
// sweep, while the register port works throughout.
module rotated_nibble_pixel_writer_unit #(
    parameter int PANEL_WIDTH  = 960,
    parameter int PANEL_HEIGHT = 540
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x [11:0], y [23:12], pixel_value [31:24], read_address [49:32]
    input  logic [55:0] s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // byte_address [17:0], byte_data [25:18]
    output logic [31:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]  m_axis_tuser
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam logic [11:0] ROW_LAST = 12'(PANEL_HEIGHT - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // gray3 scaled to 0..15 as (v*15+3)/7 gives it, rounded down.
    function automatic logic [3:0] gray3_nib(input logic [2:0] v);
        logic [3:0] n;
        case (v)
            3'd0:    n = 4'd0;
            3'd1:    n = 4'd2;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd6;
            3'd4:    n = 4'd9;
            3'd5:    n = 4'd11;
            3'd6:    n = 4'd13;
            default: n = 4'd15;
        endcase
        return n;
    endfunction

    // Alpha doubled and saturated, then inverted: at 128 and above the
    // doubled value clips to 255 and the nibble is black.
    function automatic logic [3:0] glyph_nib(input logic [7:0] a);
        logic [3:0] n;
        if (a[7]) begin
            n = 4'd0;
        end else begin
            n = 4'd15 - a[6:3];
        end
        return n;
    endfunction

    t_state r_state;

    logic drawing_enabled;
    logic clr_busy;
    logic [7:0] mem_rdata;
    rnpw_pkg::t_mem_req mem_req;

    // Item captured at acceptance.
    rnpw_pkg::t_kind r_kind;
    logic [11:0]     r_x;
    logic [11:0]     r_y;
    logic [7:0]      r_pv;
    logic [17:0]     r_ra;
    logic            r_en;

    // Decoded item.
    rnpw_pkg::t_status r_status;
    rnpw_pkg::t_waddr  r_addr;
    logic              r_rd;
    logic [3:0]        r_nib;
    logic              r_hi;

    // Result register.
    logic              r_out_valid;
    rnpw_pkg::t_status r_out_status;
    logic [17:0]       r_out_addr;
    logic [7:0]        r_out_data;

    rnpw_pkg::t_status n_status;
    rnpw_pkg::t_waddr  n_addr;
    logic              n_rd;
    logic [3:0]        n_nib;
    logic [7:0]        n_data;

    logic              in_fire;
    logic              out_load;
    logic [11:0]       row;
    logic              clipped;
    logic              read_ok;

    rnpw_apb_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_drawing_enabled (drawing_enabled)
    );

    rnpw_frame_mem #(
        .DEPTH (STORE_BYTES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rdata    (mem_rdata),
        .o_clr_busy (clr_busy)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !clr_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Rotation and clipping. The row is only meaningful when x is in range.
    assign row     = ROW_LAST - r_x;
    assign clipped = ({1'b0, r_x} >= 13'(PANEL_HEIGHT)) || ({1'b0, r_y} >= 13'(PANEL_WIDTH));
    assign read_ok = rnpw_pkg::t_waddr'(r_ra) < rnpw_pkg::t_waddr'(STORE_BYTES);

    always_comb begin
        n_status = rnpw_pkg::ST_REFUSED;
        n_addr   = '0;
        n_rd     = 1'b0;
        n_nib    = r_pv[7:4];
        case (r_kind)
            rnpw_pkg::KIND_GLYPH: n_nib = glyph_nib(r_pv);
            rnpw_pkg::KIND_GRAY3: n_nib = gray3_nib(r_pv[2:0]);
            default:              n_nib = r_pv[7:4];
        endcase
        if (!r_en) begin
            n_status = rnpw_pkg::ST_REFUSED;
        end else if (r_kind == rnpw_pkg::KIND_READ) begin
            n_addr   = rnpw_pkg::t_waddr'(r_ra);
            n_rd     = read_ok;
            n_status = read_ok ? rnpw_pkg::ST_READ : rnpw_pkg::ST_REFUSED;
        end else if (clipped) begin
            n_status = rnpw_pkg::ST_CLIPPED;
        end else begin
            n_addr = rnpw_pkg::t_waddr'(row) * rnpw_pkg::t_waddr'(ROW_BYTES)
                   + rnpw_pkg::t_waddr'(r_y[11:1]);
            n_rd   = 1'b1;
            // A glyph below alpha 8 ends as a white nibble and is left alone.
            if (r_kind == rnpw_pkg::KIND_GLYPH && r_pv < 8'd8) begin
                n_status = rnpw_pkg::ST_SKIPPED;
            end else begin
                n_status = rnpw_pkg::ST_WRITTEN;
            end
        end
    end

    // Byte handed back: the merged byte for a write, the stored byte for a
    // read or a skipped glyph, zero otherwise.
    always_comb begin
        case (r_status) inside
            rnpw_pkg::ST_WRITTEN: n_data = r_hi ? {r_nib, mem_rdata[3:0]}
                                                : {mem_rdata[7:4], r_nib};
            rnpw_pkg::ST_READ, rnpw_pkg::ST_SKIPPED: n_data = mem_rdata;
            default: n_data = 8'd0;
        endcase
    end

    always_comb begin
        mem_req       = '0;
        mem_req.addr  = r_addr;
        mem_req.wdata = n_data;
        if (r_state == S_READ) begin
            mem_req.en = r_rd;
        end else if (out_load && r_status == rnpw_pkg::ST_WRITTEN) begin
            mem_req.en = 1'b1;
            mem_req.we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_fire) begin
                    r_state <= S_ADDR;
                end
                S_ADDR: r_state <= S_READ;
                S_READ: r_state <= S_DONE;
                S_DONE: if (out_load) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= rnpw_pkg::t_kind'(s_axis_tuser);
            r_x    <= s_axis_tdata[11:0];
            r_y    <= s_axis_tdata[23:12];
            r_pv   <= s_axis_tdata[31:24];
            r_ra   <= s_axis_tdata[49:32];
            r_en   <= drawing_enabled;
        end
        if (r_state == S_ADDR) begin
            r_status <= n_status;
            r_addr   <= n_addr;
            r_rd     <= n_rd;
            r_nib    <= n_nib;
            r_hi     <= r_y[0];
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_addr[17:0];
            r_out_data   <= n_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_data, r_out_addr};
    assign m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_accept_to_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_ADDR)
        else $error("accepted word did not move to address stage");

    a_no_access_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !mem_req.en)
        else $error("frame memory accessed during clearing sweep");

    a_write_only_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_status == rnpw_pkg::ST_WRITTEN) && (r_state == S_DONE))
        else $error("frame memory written for an item that is not a pixel write");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(r_state == S_DONE))
        else $error("result word appeared without a finished item");
`endif

endmodule
